### src/afrf_pkg.sv
// ----------------------------------------------------------------------------
// afrf_pkg
// Shared widths, register indexes and reset values for the audio FIFO
// writer with rate feedback.
// ----------------------------------------------------------------------------
package afrf_pkg;

  localparam int BUF_SIZE_DEF = 255;

  localparam int WORD_W   = 32;
  localparam int IDX_W    = 8;
  localparam int FILL_W   = 8;
  localparam int COUNT_W  = 32;
  localparam int RATE_W   = 20;
  localparam int FB_W     = 24;
  localparam int CFG_IDX_W = 2;

  // item kinds
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW  = 2'd2;

  localparam int RATE_HIGH_RST = 44060;
  localparam int RATE_MID_RST  = 44100;
  localparam int RATE_LOW_RST  = 44140;

  // 10.14 feedback words for the reset rates
  localparam logic [FB_W-1:0] FB_HIGH_RST =
    FB_W'(((RATE_HIGH_RST / 1000) << 14) | ((RATE_HIGH_RST % 1000) << 4));
  localparam logic [FB_W-1:0] FB_MID_RST =
    FB_W'(((RATE_MID_RST / 1000) << 14) | ((RATE_MID_RST % 1000) << 4));
  localparam logic [FB_W-1:0] FB_LOW_RST =
    FB_W'(((RATE_LOW_RST / 1000) << 14) | ((RATE_LOW_RST % 1000) << 4));

  typedef struct packed {
    logic [FB_W-1:0] high;
    logic [FB_W-1:0] mid;
    logic [FB_W-1:0] low;
  } afrf_fb_set_t;

endpackage

### src/afrf_in_if.sv
// ----------------------------------------------------------------------------
// afrf_in_if
// Input channel: audio frame words and start-of-frame ticks.
// ----------------------------------------------------------------------------
interface afrf_in_if;
  import afrf_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [WORD_W-1:0] frame_word;
  logic             last_of_packet;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, func, frame_word, last_of_packet, read_index,
                  input ready);
  modport sink   (input valid, func, frame_word, last_of_packet, read_index,
                  output ready);
endinterface

### src/afrf_out_if.sv
// ----------------------------------------------------------------------------
// afrf_out_if
// Result channel: ring buffer write, playback start and rate feedback.
// ----------------------------------------------------------------------------
interface afrf_out_if;
  import afrf_pkg::*;

  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [IDX_W-1:0]   write_index;
  logic [WORD_W-1:0]  write_data;
  logic              overrun_event;
  logic              start_playback;
  logic              feedback_valid;
  logic [FB_W-1:0]    feedback_value;
  logic [FILL_W-1:0]  fill_level;
  logic [COUNT_W-1:0] overrun_total;

  modport source (output valid, write_enable, write_index, write_data,
                  overrun_event, start_playback, feedback_valid,
                  feedback_value, fill_level, overrun_total,
                  input ready);
  modport sink   (input valid, write_enable, write_index, write_data,
                  overrun_event, start_playback, feedback_valid,
                  feedback_value, fill_level, overrun_total,
                  output ready);
endinterface

### src/afrf_rate_regs.sv
// ----------------------------------------------------------------------------
// afrf_rate_regs
// Rate registers. Each write to a rate index converts Hz into the 10.14
// feedback word (kHz in the upper bits, other Hz shifted left 4), stored.
// ----------------------------------------------------------------------------
module afrf_rate_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [afrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afrf_pkg::RATE_W-1:0]    cfg_data,
  output afrf_pkg::afrf_fb_set_t         fb_set
);
  import afrf_pkg::*;

  localparam int RECIP   = 1048;  // floor(2^20 / 1000)
  localparam int RECIP_W = 11;
  localparam int PROD_W  = RATE_W + RECIP_W;
  localparam int Q_W     = 11;
  localparam int REM_W   = 21;

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q0;
  logic [REM_W-1:0]  q0_x1000;
  logic [REM_W-1:0]  rem0;
  logic [Q_W-1:0]    khz;
  logic [REM_W-1:0]  hz;
  logic [FB_W-1:0]   fb_new;

  afrf_fb_set_t fb_r, fb_nxt;

  // reciprocal estimate is low by at most one
  always_comb begin
    prod     = PROD_W'(cfg_data) * PROD_W'(RECIP);
    q0       = prod[PROD_W-1 -: Q_W];
    q0_x1000 = (REM_W'(q0) << 10) - (REM_W'(q0) << 4) - (REM_W'(q0) << 3);
    rem0     = REM_W'(cfg_data) - q0_x1000;
    if (rem0 >= REM_W'(1000)) begin
      khz = q0 + Q_W'(1);
      hz  = rem0 - REM_W'(1000);
    end else begin
      khz = q0;
      hz  = rem0;
    end
    fb_new = {khz[9:0], hz[9:0], 4'b0000};
  end

  always_comb begin
    fb_nxt = fb_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATE_HIGH: fb_nxt.high = fb_new;
        CFG_RATE_MID:  fb_nxt.mid  = fb_new;
        CFG_RATE_LOW:  fb_nxt.low  = fb_new;
        default:       fb_nxt      = fb_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r.high <= FB_HIGH_RST;
      fb_r.mid  <= FB_MID_RST;
      fb_r.low  <= FB_LOW_RST;
    end else begin
      fb_r <= fb_nxt;
    end
  end

  assign fb_set = fb_r;

endmodule

### src/audio_fifo_rate_feedback.sv
// ----------------------------------------------------------------------------
// audio_fifo_rate_feedback
// Ring buffer writer for asynchronous audio streaming with rate feedback.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A new item is taken every cycle unless the
// output stalls; each item goes through the input and result registers.
// Frame beats advance the write pointer over BUF_SIZE+1 slots and emit a
// buffer write unless the next slot is the read slot, in which case the
// frame is dropped, counted, and the rest of its packet skipped. Tick beats
// report the fill level and a 10.14 feedback word picked by fill thirds.
// The pointer update and fill compare form the loop that sets
// the rate; Hz to feedback conversion happens at register write time, so
// the rate registers may be written only while the block is idle.
module audio_fifo_rate_feedback #(
  parameter int BUF_SIZE = afrf_pkg::BUF_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  afrf_in_if.sink                       in_ch,
  afrf_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [afrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afrf_pkg::RATE_W-1:0]    cfg_data
);
  import afrf_pkg::*;

  localparam int SLOTS  = BUF_SIZE + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CMP_W  = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
  localparam int THR_HALF = BUF_SIZE / 2;
  localparam int THR_LO   = BUF_SIZE / 3;
  localparam int THR_HI   = BUF_SIZE / 3 * 2;
  localparam int RD_VALS  = 1 << IDX_W;

  typedef struct packed {
    logic              write_enable;
    logic [IDX_W-1:0]   write_index;
    logic [WORD_W-1:0]  write_data;
    logic              overrun_event;
    logic              start_playback;
    logic              feedback_valid;
    logic [FB_W-1:0]    feedback_value;
    logic [FILL_W-1:0]  fill_level;
    logic [COUNT_W-1:0] overrun_total;
  } result_t;

  afrf_fb_set_t fb_set;

  afrf_rate_regs u_rate_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fb_set    (fb_set)
  );

  // read slot reduced modulo SLOTS
  logic [SLOT_W-1:0] rd_mod_tbl [RD_VALS];
  for (genvar i = 0; i < RD_VALS; i++) begin : g_rd_mod
    assign rd_mod_tbl[i] = SLOT_W'(i % SLOTS);
  end

  // handshake
  logic in_valid_r, out_valid_r;
  logic out_adv, s1_adv, in_acc;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || out_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_adv      = in_valid_r && out_adv;

  // input register
  logic              func_r;
  logic [WORD_W-1:0] word_r;
  logic              last_r;
  logic [IDX_W-1:0]  rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_ch.func;
      word_r <= in_ch.frame_word;
      last_r <= in_ch.last_of_packet;
      rd_r   <= in_ch.read_index;
    end
  end

  // block state
  logic [SLOT_W-1:0]  write_slot_r, write_slot_nxt;
  logic               playing_r, playing_nxt;
  logic               dropping_r, dropping_nxt;
  logic [COUNT_W-1:0] overrun_count_r, overrun_count_nxt;

  logic [SLOT_W-1:0]  next_slot;
  logic [CMP_W-1:0]   next_ext;
  logic               full;
  logic [SLOT_W:0]    diff;
  logic [SLOT_W-1:0]  fill;
  logic [CMP_W-1:0]   fill_ext;
  result_t            res;

  always_comb begin
    next_slot = (write_slot_r < SLOT_W'(BUF_SIZE)) ? write_slot_r + SLOT_W'(1) : '0;
    next_ext  = CMP_W'(next_slot);
    // raw compare: an out-of-range read slot never reads as full
    full      = (next_ext == CMP_W'(rd_r));
    diff      = {1'b0, write_slot_r} - {1'b0, rd_mod_tbl[rd_r]};
    fill      = diff[SLOT_W] ? SLOT_W'(diff + (SLOT_W+1)'(SLOTS)) : diff[SLOT_W-1:0];
    fill_ext  = CMP_W'(fill);

    write_slot_nxt    = write_slot_r;
    playing_nxt       = playing_r;
    dropping_nxt      = dropping_r;
    overrun_count_nxt = overrun_count_r;
    res               = '0;

    if (func_r == FUNC_FRAME) begin
      if (dropping_r) begin
        if (last_r) begin
          dropping_nxt = 1'b0;
        end
      end else if (!full) begin
        write_slot_nxt   = next_slot;
        res.write_enable = 1'b1;
        res.write_index  = next_ext[IDX_W-1:0];
        res.write_data   = word_r;
      end else begin
        res.overrun_event = 1'b1;
        if (!playing_r) begin
          playing_nxt        = 1'b1;
          res.start_playback = 1'b1;
        end
        overrun_count_nxt = overrun_count_r + COUNT_W'(1);
        dropping_nxt      = !last_r;
      end
    end else begin
      if (!playing_r && (fill > SLOT_W'(THR_HALF))) begin
        playing_nxt        = 1'b1;
        res.start_playback = 1'b1;
      end
      priority if (fill > SLOT_W'(THR_HI)) begin
        res.feedback_value = fb_set.high;
      end else if (fill > SLOT_W'(THR_LO)) begin
        res.feedback_value = fb_set.mid;
      end else begin
        res.feedback_value = fb_set.low;
      end
      res.feedback_valid = 1'b1;
      res.fill_level     = fill_ext[FILL_W-1:0];
    end
    res.overrun_total = overrun_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r    <= '0;
      playing_r       <= 1'b0;
      dropping_r      <= 1'b0;
      overrun_count_r <= '0;
    end else if (s1_adv) begin
      write_slot_r    <= write_slot_nxt;
      playing_r       <= playing_nxt;
      dropping_r      <= dropping_nxt;
      overrun_count_r <= overrun_count_nxt;
    end
  end

  // result register
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.write_enable   = res_r.write_enable;
  assign out_ch.write_index    = res_r.write_index;
  assign out_ch.write_data     = res_r.write_data;
  assign out_ch.overrun_event  = res_r.overrun_event;
  assign out_ch.start_playback = res_r.start_playback;
  assign out_ch.feedback_valid = res_r.feedback_valid;
  assign out_ch.feedback_value = res_r.feedback_value;
  assign out_ch.fill_level     = res_r.fill_level;
  assign out_ch.overrun_total  = res_r.overrun_total;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio ring buffer writer with rate feedback.
// A scoreboard class predicts each result beat from the accepted input beats
// and the programmed rates. Frames and ticks are driven as packets that
// follow a simulated player position, with the buffer often pushed to full.
// Rate registers are reprogrammed between phases, and both sides throttle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import afrf_pkg::*;

  localparam int BUF_SIZE    = BUF_SIZE_DEF;
  localparam int SLOTS       = BUF_SIZE + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;
  localparam int PHASES      = 6;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] word;
    logic              last;
    logic [IDX_W-1:0]  rd;
  } afrf_item_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   widx;
    logic [WORD_W-1:0]  wdata;
    logic               ovr;
    logic               start;
    logic               fbv;
    logic [FB_W-1:0]    fb;
    logic [FILL_W-1:0]  fill;
    logic [COUNT_W-1:0] ovr_total;
  } afrf_result_t;

  class ring_writer_sb;
    logic [RATE_W-1:0]  rate_hz [3];
    int                 wr_slot;
    bit                 playing;
    bit                 dropping;
    logic [COUNT_W-1:0] ovr_count;
    afrf_result_t       awaited [$];
    int                 errors;
    int                 checked;
    int                 overruns;
    int                 ticks;

    function new();
      rate_hz[CFG_RATE_HIGH] = RATE_W'(RATE_HIGH_RST);
      rate_hz[CFG_RATE_MID]  = RATE_W'(RATE_MID_RST);
      rate_hz[CFG_RATE_LOW]  = RATE_W'(RATE_LOW_RST);
      wr_slot   = 0;
      playing   = 1'b0;
      dropping  = 1'b0;
      ovr_count = '0;
      errors    = 0;
      checked   = 0;
      overruns  = 0;
      ticks     = 0;
    endfunction

    function void set_rate(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] hz);
      rate_hz[idx] = hz;
    endfunction

    // whole kHz in the upper bits, leftover Hz above the low nibble
    function logic [FB_W-1:0] feedback_word(logic [RATE_W-1:0] hz);
      int unsigned khz;
      int unsigned rem;
      khz = hz / 1000;
      rem = hz % 1000;
      return FB_W'((khz << 14) | (rem << 4));
    endfunction

    function void take_item(afrf_item_t it);
      afrf_result_t      r;
      int                nxt;
      int                fill;
      logic [RATE_W-1:0] hz;
      r = '0;
      if (it.func == FUNC_FRAME) begin
        if (dropping) begin
          if (it.last) dropping = 1'b0;
        end else begin
          nxt = (wr_slot < BUF_SIZE) ? wr_slot + 1 : 0;
          // full test uses the raw read slot
          if (nxt != int'(it.rd)) begin
            wr_slot = nxt;
            r.we    = 1'b1;
            r.widx  = IDX_W'(nxt);
            r.wdata = it.word;
          end else begin
            r.ovr = 1'b1;
            if (!playing) begin
              playing = 1'b1;
              r.start = 1'b1;
            end
            ovr_count = ovr_count + 1'b1;
            dropping  = !it.last;
            overruns++;
          end
        end
      end else begin
        fill = (wr_slot + SLOTS - (int'(it.rd) % SLOTS)) % SLOTS;
        if (!playing && fill > BUF_SIZE / 2) begin
          playing = 1'b1;
          r.start = 1'b1;
        end
        if (fill > BUF_SIZE / 3 * 2) hz = rate_hz[CFG_RATE_HIGH];
        else if (fill > BUF_SIZE / 3) hz = rate_hz[CFG_RATE_MID];
        else hz = rate_hz[CFG_RATE_LOW];
        r.fbv  = 1'b1;
        r.fb   = feedback_word(hz);
        r.fill = FILL_W'(fill);
        ticks++;
      end
      r.ovr_total = ovr_count;
      awaited.push_back(r);
    endfunction

    function void check_beat(afrf_result_t got);
      afrf_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat at %0t: we=%0b idx=%0d data=%h fb=%h",
                   $realtime, got.we, got.widx, got.wdata, got.fb);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch on result %0d at %0t", checked, $realtime);
          $display(
            "  exp: we=%0b idx=%0d data=%h ovr=%0b start=%0b fbv=%0b fb=%h fill=%0d tot=%0d",
            want.we, want.widx, want.wdata, want.ovr, want.start, want.fbv,
            want.fb, want.fill, want.ovr_total);
          $display(
            "  got: we=%0b idx=%0d data=%h ovr=%0b start=%0b fbv=%0b fb=%h fill=%0d tot=%0d",
            got.we, got.widx, got.wdata, got.ovr, got.start, got.fbv,
            got.fb, got.fill, got.ovr_total);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATE_W-1:0]    cfg_data;

  afrf_in_if  in_ch ();
  afrf_out_if out_ch ();

  audio_fifo_rate_feedback u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ring_writer_sb sb = new();

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   player      = 0;
  int   player_speed = 1;
  int   items_sent  = 0;
  int   cycles      = 0;
  logic rx_hold     = 1'b0;
  logic pressure_go = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycles, sb.awaited.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side: check accepted beats, throttle ready
  always @(posedge clk) begin
    afrf_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.we        = out_ch.write_enable;
      got.widx      = out_ch.write_index;
      got.wdata     = out_ch.write_data;
      got.ovr       = out_ch.overrun_event;
      got.start     = out_ch.start_playback;
      got.fbv       = out_ch.feedback_valid;
      got.fb        = out_ch.feedback_value;
      got.fill      = out_ch.fill_level;
      got.ovr_total = out_ch.overrun_total;
      sb.check_beat(got);
    end
    out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (pressure_go);
    repeat (10) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_item(input afrf_item_t it);
    in_ch.func           <= it.func;
    in_ch.frame_word     <= it.word;
    in_ch.last_of_packet <= it.last;
    in_ch.read_index     <= it.rd;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_item(it);
    items_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send(input logic func, input logic [WORD_W-1:0] word,
                      input logic last, input logic [IDX_W-1:0] rd);
    afrf_item_t it;
    it.func = func;
    it.word = word;
    it.last = last;
    it.rd   = rd;
    send_item(it);
  endtask

  task automatic write_rate(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] hz);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= hz;
    @(posedge clk);
    sb.set_rate(idx, hz);
  endtask

  task automatic wait_drain();
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // read slot as the player would report it; sometimes pinned right at full
  function automatic logic [IDX_W-1:0] pick_read();
    int sel;
    int fill;
    int adv;
    sel  = $urandom_range(0, 99);
    fill = (sb.wr_slot + SLOTS - player) % SLOTS;
    adv  = $urandom_range(0, player_speed);
    if (adv > fill) adv = fill;
    player = (player + adv) % SLOTS;
    if (sel < 60) return IDX_W'(player);
    if (sel < 75) return IDX_W'((sb.wr_slot + 1) % SLOTS);
    if (sel < 85) begin
      player = (sb.wr_slot + 1 + $urandom_range(0, 8)) % SLOTS;
      return IDX_W'(player);
    end
    return IDX_W'($urandom_range(0, 255));
  endfunction

  task automatic overrun_burst();
    send(FUNC_FRAME, 32'hFFFF_FFFF, 1'b0, 8'd1);  // full, packet now dropped
    send(FUNC_FRAME, 32'h0000_0000, 1'b0, 8'd1);  // ignored
    send(FUNC_FRAME, 32'hA5A5_5A5A, 1'b1, 8'd1);  // ignored, ends the drop
    send(FUNC_FRAME, $urandom, 1'b1, 8'd1);        // full on last beat
  endtask

  task automatic run_directed();
    bit overrun_first;
    overrun_first = $urandom_range(0, 1);
    send(FUNC_TICK, $urandom, 1'b0, 8'd0);    // empty
    send(FUNC_TICK, $urandom, 1'b1, 8'd129);  // fill 127, just below half
    send(FUNC_TICK, 32'h0, 1'b0, 8'd171);     // fill 85, top of low third
    send(FUNC_TICK, 32'h0, 1'b0, 8'd170);     // fill 86, bottom of mid third
    // playback start comes from whichever happens first
    if (overrun_first) begin
      overrun_burst();
      send(FUNC_TICK, 32'h0, 1'b0, 8'd85);    // fill 171, high third
    end else begin
      send(FUNC_TICK, 32'h0, 1'b0, 8'd85);
      overrun_burst();
    end
    send(FUNC_FRAME, 32'h0000_0000, 1'b0, 8'd0);
    send(FUNC_FRAME, 32'hFFFF_FFFF, 1'b1, 8'd255);
    send(FUNC_TICK, 32'hFFFF_FFFF, 1'b1, 8'd2);
    send(FUNC_TICK, 32'h0, 1'b0, 8'd255);
    send(FUNC_FRAME, $urandom, 1'b1, 8'd3);   // full, single-beat packet
    send(FUNC_TICK, 32'h0, 1'b0, 8'd3);       // fill 255
    send(FUNC_FRAME, $urandom, 1'b1, 8'd200);
  endtask

  task automatic run_random(input int n_items);
    int         count;
    int         len;
    afrf_item_t it;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(0, 99) < 8) begin
        // noise beat
        it.func = $urandom_range(0, 1);
        it.word = $urandom;
        it.last = $urandom_range(0, 1);
        it.rd   = $urandom_range(0, 255);
        count++;
        send_item(it);
      end
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        it.func = FUNC_FRAME;
        it.word = $urandom;
        it.last = (k == len - 1);
        if ($urandom_range(0, 99) < 4) it.last = ~it.last;
        it.rd = pick_read();
        count++;
        send_item(it);
      end
      if ($urandom_range(0, 1)) begin
        it.func = FUNC_TICK;
        it.word = $urandom;
        it.last = $urandom_range(0, 1);
        it.rd   = pick_read();
        count++;
        send_item(it);
      end
    end
  endtask

  initial begin
    logic [RATE_W-1:0] rate_plan [PHASES][3];

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_FRAME;
    in_ch.frame_word     = '0;
    in_ch.last_of_packet = 1'b0;
    in_ch.read_index     = '0;
    out_ch.ready         = 1'b0;

    // high / mid / low rates per phase
    rate_plan[0] = '{20'd0, 20'd1023999, 20'd999};
    rate_plan[1] = '{RATE_W'($urandom_range(0, 1023999)), RATE_W'($urandom_range(0, 1023999)),
                     RATE_W'($urandom_range(0, 1023999))};
    rate_plan[2] = '{20'hFFFFF, 20'd1000, 20'd0};  // top value overflows the 24-bit word
    rate_plan[3] = '{RATE_W'($urandom_range(0, 1023999)), RATE_W'($urandom_range(0, 1023999)),
                     RATE_W'($urandom_range(1024000, 20'hFFFFF))};
    rate_plan[4] = '{20'd47990, 20'd48000, 20'd48010};
    rate_plan[5] = '{RATE_W'(RATE_HIGH_RST), RATE_W'(RATE_MID_RST), RATE_W'(RATE_LOW_RST)};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    in_ch.valid <= 1'b0;
    wait_drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        tx_idle_pct = 30;
        rx_idle_pct = 53;
      end else if (p < 4) begin
        tx_idle_pct = 53;
        rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      player_speed = $urandom_range(0, 3);
      write_rate(CFG_RATE_HIGH, rate_plan[p][0]);
      write_rate(CFG_RATE_MID, rate_plan[p][1]);
      write_rate(CFG_RATE_LOW, rate_plan[p][2]);
      cfg_we <= 1'b0;
      if (p == 1) pressure_go <= 1'b1;
      run_random(115);
      in_ch.valid <= 1'b0;
      wait_drain();
    end

    $display("run covered %0d input beats and %0d checked results over %0d rate settings",
             items_sent, sb.checked, PHASES + 1);
    $display("predicted %0d overruns and %0d feedback ticks; %0d errors",
             sb.overruns, sb.ticks, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
